>>> rtl/spfs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spfs_pkg
// Shared types and codes for the supply and pressure fault supervisor.
// ---------------------------------------------------------------------------
package spfs_pkg;

    // item kinds
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_STARTUP  = 2'd1;
    localparam logic [1:0] OP_SHUTDOWN = 2'd2;

    // modes
    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_RUN     = 2'd1;
    localparam logic [1:0] MODE_TRIPPED = 2'd2;

    // fault codes
    localparam logic [1:0] FC_NONE  = 2'd0;
    localparam logic [1:0] FC_LOWV  = 2'd1;
    localparam logic [1:0] FC_SENS  = 2'd2;
    localparam logic [1:0] FC_OVERP = 2'd3;

    // alarm beep counts per fault
    localparam logic [2:0] BEEPS_LOWV  = 3'd2;
    localparam logic [2:0] BEEPS_SENS  = 3'd3;
    localparam logic [2:0] BEEPS_OVERP = 3'd5;

    // register byte addresses
    localparam logic [4:0]  ADDR_VIN_TRIP    = 5'd0;
    localparam logic [4:0]  ADDR_VIN_RECOVER = 5'd4;
    localparam logic [4:0]  ADDR_VIN_HOLD    = 5'd8;
    localparam logic [4:0]  ADDR_MAX_PRESS   = 5'd12;
    localparam logic [4:0]  ADDR_ADV_TIMEOUT = 5'd16;

    // reset values
    localparam logic [15:0] RST_VIN_TRIP    = 16'd9800;
    localparam logic [15:0] RST_VIN_RECOVER = 16'd10300;
    localparam logic [15:0] RST_VIN_HOLD    = 16'd200;
    localparam logic [14:0] RST_MAX_PRESS   = 15'd3000;
    localparam logic [31:0] RST_ADV_TIMEOUT = 32'd30000;

    typedef struct packed {
        logic [15:0] vin_trip_mv;
        logic [15:0] vin_recover_mv;
        logic [15:0] vin_hold_ms;
        logic [14:0] max_mask_pressure;
        logic [31:0] adv_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        now_ms;
        logic [15:0]        vin_mv;
        logic               sensors_ok;
        logic signed [15:0] mask_pressure;
        logic               adv_active;
        logic [31:0]        adv_start_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] fault_code;
        logic       fault_event;
        logic [2:0] beep_count;
        logic       motor_stop;
        logic       motor_restart;
        logic       therapy_step;
        logic       stop_advertising;
    } result_t;

endpackage

>>> rtl/supply_pressure_fault_supervisor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// supply_pressure_fault_supervisor
// Mode and fault supervisor for a blower: supply, sensor, overpressure and
// advertising-timeout checks with a registered single-pass datapath.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per item: tuser holds the opcode (tick, startup
//   or shutdown request), tdata the time stamp, supply voltage, sensor flag,
//   mask pressure and advertising state. m_axis returns one result word per
//   input word, in order: mode, fault code and the event flags.
//   The APB port writes and reads the five threshold/timeout registers;
//   write them only while no word is in flight.
// Timing:
//   a word sits in the input register, is evaluated against the
//   supervisor state by one pass of compare/subtract logic and lands in the
//   result register; one word per cycle sustained while m_tready is high.
// Reset:
//   aresetn (synchronous, low) empties both stages, sets mode standby, fault
//   none, clears the low-supply timer and loads register defaults.
// Stall:
//   while m_tready is low a finished word holds; the input register still
//   fills, after which s_tready drops until the result drains.
// ---------------------------------------------------------------------------
module supply_pressure_fault_supervisor (
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_ms[31:0], vin_mv[47:32], sensors_ok[48], mask_pressure[64:49],
    // adv_active[65], adv_start_ms[97:66], zero fill[103:98]
    input  logic [103:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    // mode[1:0], fault_code[3:2], fault_event[4], beep_count[7:5],
    // motor_stop[8], motor_restart[9], therapy_step[10],
    // stop_advertising[11], zero fill[15:12]
    output logic [15:0]  m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import spfs_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result, result_reg;
    logic    out_valid_reg;
    logic    out_free, advance, in_load;

    // pipeline control
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_load  = s_tvalid && s_tready;

    spfs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spfs_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_load) begin
            item_reg.opcode        <= s_tuser;
            item_reg.now_ms        <= s_tdata[31:0];
            item_reg.vin_mv        <= s_tdata[47:32];
            item_reg.sensors_ok    <= s_tdata[48];
            item_reg.mask_pressure <= s_tdata[64:49];
            item_reg.adv_active    <= s_tdata[65];
            item_reg.adv_start_ms  <= s_tdata[97:66];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, result_reg.stop_advertising, result_reg.therapy_step,
                       result_reg.motor_restart, result_reg.motor_stop,
                       result_reg.beep_count, result_reg.fault_event,
                       result_reg.fault_code, result_reg.mode};

endmodule

>>> rtl/spfs_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spfs_cfg_regs
// Register bank behind the configuration port: threshold and timeout values.
// ---------------------------------------------------------------------------
module spfs_cfg_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output spfs_pkg::cfg_t       cfg
);
    import spfs_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vin_trip_mv       <= RST_VIN_TRIP;
            cfg_reg.vin_recover_mv    <= RST_VIN_RECOVER;
            cfg_reg.vin_hold_ms       <= RST_VIN_HOLD;
            cfg_reg.max_mask_pressure <= RST_MAX_PRESS;
            cfg_reg.adv_timeout_ms    <= RST_ADV_TIMEOUT;
        end else if (wr_en) begin
            unique case (paddr)
                ADDR_VIN_TRIP:    cfg_reg.vin_trip_mv       <= pwdata[15:0];
                ADDR_VIN_RECOVER: cfg_reg.vin_recover_mv    <= pwdata[15:0];
                ADDR_VIN_HOLD:    cfg_reg.vin_hold_ms       <= pwdata[15:0];
                ADDR_MAX_PRESS:   cfg_reg.max_mask_pressure <= pwdata[14:0];
                ADDR_ADV_TIMEOUT: cfg_reg.adv_timeout_ms    <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr)
            ADDR_VIN_TRIP:    prdata = {16'd0, cfg_reg.vin_trip_mv};
            ADDR_VIN_RECOVER: prdata = {16'd0, cfg_reg.vin_recover_mv};
            ADDR_VIN_HOLD:    prdata = {16'd0, cfg_reg.vin_hold_ms};
            ADDR_MAX_PRESS:   prdata = {17'd0, cfg_reg.max_mask_pressure};
            ADDR_ADV_TIMEOUT: prdata = cfg_reg.adv_timeout_ms;
            default:          prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/spfs_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spfs_step
// Supervisor state (mode, fault, low-supply timer) and the per-word decision
// logic; state advances on each word that moves into the result register.
// ---------------------------------------------------------------------------
module spfs_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  spfs_pkg::cfg_t    cfg,
    input  spfs_pkg::item_t   item,
    output spfs_pkg::result_t result
);
    import spfs_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  fault_reg, fault_next;
    logic        low_valid_reg, low_valid_next;
    logic [31:0] low_start_reg, low_start_next;

    logic        ev_fault, ev_stop, ev_restart, therapy, stop_adv, done;
    logic [2:0]  ev_beeps;
    logic [31:0] low_elapsed, adv_elapsed;
    logic        over_press;

    // a timer started by this tick is not checked against the hold time on this tick
    assign low_elapsed = item.now_ms - low_start_reg;
    assign adv_elapsed = item.now_ms - item.adv_start_ms;
    assign over_press  = item.mask_pressure > $signed({1'b0, cfg.max_mask_pressure});

    // decision logic, in the order checks apply on a tick
    always_comb begin
        mode_next      = mode_reg;
        fault_next     = fault_reg;
        low_valid_next = low_valid_reg;
        low_start_next = low_start_reg;
        ev_fault       = 1'b0;
        ev_beeps       = 3'd0;
        ev_stop        = 1'b0;
        ev_restart     = 1'b0;
        therapy        = 1'b0;
        stop_adv       = 1'b0;
        done           = 1'b0;

        case (item.opcode)
            OP_TICK: begin
                // supply check and low-supply recovery
                if (mode_reg != MODE_TRIPPED) begin
                    if (item.vin_mv < cfg.vin_trip_mv) begin
                        if (!low_valid_reg) begin
                            low_valid_next = 1'b1;
                            low_start_next = item.now_ms;
                        end
                        if (low_valid_reg && low_elapsed > {16'd0, cfg.vin_hold_ms}) begin
                            fault_next = FC_LOWV;
                            ev_fault   = 1'b1;
                            ev_beeps   = BEEPS_LOWV;
                            mode_next  = MODE_TRIPPED;
                            ev_stop    = 1'b1;
                        end
                    end else begin
                        low_valid_next = 1'b0;
                    end
                end else if (fault_reg == FC_LOWV && item.vin_mv > cfg.vin_recover_mv) begin
                    mode_next = MODE_STANDBY;
                    ev_stop   = 1'b1;
                end
                // sensor health and overpressure
                if (!item.sensors_ok) begin
                    done = 1'b1;
                    if (!(fault_next == FC_SENS && mode_next == MODE_TRIPPED)) begin
                        fault_next = FC_SENS;
                        ev_fault   = 1'b1;
                        ev_beeps   = BEEPS_SENS;
                        if (mode_next != MODE_TRIPPED) begin
                            mode_next = MODE_TRIPPED;
                            ev_stop   = 1'b1;
                        end
                    end
                end else if (over_press) begin
                    done = 1'b1;
                    if (!(fault_next == FC_OVERP && mode_next == MODE_TRIPPED)) begin
                        fault_next = FC_OVERP;
                        ev_fault   = 1'b1;
                        ev_beeps   = BEEPS_OVERP;
                        if (mode_next != MODE_TRIPPED) begin
                            mode_next = MODE_TRIPPED;
                            ev_stop   = 1'b1;
                        end
                    end
                end
                // therapy step and advertising timeout
                if (!done) begin
                    therapy = 1'b1;
                    if (item.adv_active && adv_elapsed > cfg.adv_timeout_ms) begin
                        stop_adv = 1'b1;
                        if (mode_next != MODE_STANDBY) begin
                            mode_next = MODE_STANDBY;
                            ev_stop   = 1'b1;
                        end
                    end
                end
            end
            OP_STARTUP: begin
                ev_restart = 1'b1;
                mode_next  = MODE_RUN;
            end
            OP_SHUTDOWN: begin
                ev_stop   = 1'b1;
                mode_next = MODE_STANDBY;
            end
            default: ;
        endcase
    end

    // result word
    always_comb begin
        result.mode             = mode_next;
        result.fault_code       = fault_next;
        result.fault_event      = ev_fault;
        result.beep_count       = ev_beeps;
        result.motor_stop       = ev_stop;
        result.motor_restart    = ev_restart;
        result.therapy_step     = therapy;
        result.stop_advertising = stop_adv;
    end

    // supervisor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_STANDBY;
            fault_reg     <= FC_NONE;
            low_valid_reg <= 1'b0;
            low_start_reg <= 32'd0;
        end else if (step_en) begin
            mode_reg      <= mode_next;
            fault_reg     <= fault_next;
            low_valid_reg <= low_valid_next;
            low_start_reg <= low_start_next;
        end
    end

endmodule
